// ===== src/tewq_pkg.sv =====
// Shared types and constants for the timestamped event window queue.
package tewq_pkg;

    localparam int CODE_BITS      = 16;
    localparam int TS_BITS        = 64;
    localparam int TIMEOUT_BITS   = 32;
    localparam int RING_DEPTH_DEF = 32;

    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 32'd1000000;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [CODE_BITS-1:0] event_code;
        logic [TS_BITS-1:0]   now_ts;
        logic [TS_BITS-1:0]   window_start_ts;
    } tewq_in_t;

    typedef struct packed {
        logic                 found;
        logic [CODE_BITS-1:0] event_code_out;
        logic [TS_BITS-1:0]   event_ts;
        logic                 last_item;
    } tewq_out_t;

endpackage

// ===== src/timestamped_event_window_queue.sv =====
// Top level: ring of timestamped event codes with expiry and window query.
//
// Usage:
//  - Input channel s_valid/s_ready/s_data carries one request: a push
//    (cmd = CMD_PUSH) stores event_code stamped with now_ts at the tail; a full
//    ring overwrites its oldest entry. A query (cmd = CMD_QUERY) drops head
//    entries older than now_ts - timeout (floored at zero), then, oldest first,
//    returns entries up to now_ts stored after the last one <= window_start_ts.
//  - Result channel m_valid/m_ready/m_data: one result per matching entry, the
//    final one flagged by last_item; an empty window gives a single result with
//    found = 0 and last_item = 1. Pushes give no result.
//  - cfg_wr_en/cfg_wr_data write the expiry timeout; write only while idle.
//  - A query walks the ring through the single RAM read port, one entry per
//    cycle unless a stalled receiver holds it: expiry from the head, then a
//    backward scan from the newest entry, then a forward emit pass.
//  - s_ready is high only while no query is in flight.
//  - A stalled receiver holds the emit pass at the current entry; the last
//    result sits in the output register while the next request is accepted.
//  - Reset (aresetn low, synchronous) empties the ring and restores the
//    timeout; ring storage itself is not cleared.
module timestamped_event_window_queue
    import tewq_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  tewq_in_t                s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output tewq_out_t               m_data,
    input  logic                    cfg_wr_en,
    input  logic [TIMEOUT_BITS-1:0] cfg_wr_data
);

    localparam int IDX_W   = $clog2(RING_DEPTH);
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int ENTRY_W = TS_BITS + CODE_BITS;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(RING_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_C   = CNT_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIMIT,
        ST_EXPIRE,
        ST_SCAN,
        ST_EMIT,
        ST_FINISH
    } state_t;

    // Ring slot at a given offset from a base slot; offset never exceeds depth.
    function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] base,
                                                    input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return s[IDX_W-1:0];
    endfunction

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;       // scan / emit position
    logic [TIMEOUT_BITS-1:0] timeout_reg, timeout_next;
    logic [TS_BITS-1:0]      now_reg, now_next;
    logic [TS_BITS-1:0]      start_reg, start_next;
    logic [TS_BITS-1:0]      limit_reg, limit_next;
    logic                    hold_valid_reg, hold_valid_next;
    logic [CODE_BITS-1:0]    hold_code_reg, hold_code_next;
    logic [TS_BITS-1:0]      hold_ts_reg, hold_ts_next;
    logic                    m_valid_reg, m_valid_next;
    tewq_out_t               m_data_reg, m_data_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]      ram_rdata;
    logic [TS_BITS-1:0]      rd_ts;
    logic [CODE_BITS-1:0]    rd_code;
    logic                    accept;
    logic                    full;
    logic                    out_free;
    logic [TS_BITS-1:0]      timeout_ext;

    tewq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_ts       = ram_rdata[ENTRY_W-1:CODE_BITS];
    assign rd_code     = ram_rdata[CODE_BITS-1:0];
    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign full        = (count_reg == DEPTH_C);
    assign out_free    = !m_valid_reg || m_ready;
    assign timeout_ext = TS_BITS'(timeout_reg);

    // Push writes straight into the ring on the accepting edge.
    assign ram_we    = accept && (s_data.cmd == CMD_PUSH);
    assign ram_waddr = full ? head_reg : slot_after(head_reg, count_reg);
    assign ram_wdata = {s_data.now_ts, s_data.event_code};

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        timeout_next    = cfg_wr_en ? cfg_wr_data : timeout_reg;
        now_next        = now_reg;
        start_next      = start_reg;
        limit_next      = limit_reg;
        hold_valid_next = hold_valid_reg;
        hold_code_next  = hold_code_reg;
        hold_ts_next    = hold_ts_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        ram_raddr       = head_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.cmd == CMD_PUSH) begin
                        if (full) begin
                            head_next = slot_after(head_reg, ONE_C);
                        end else begin
                            count_next = count_reg + ONE_C;
                        end
                    end else begin
                        now_next        = s_data.now_ts;
                        start_next      = s_data.window_start_ts;
                        hold_valid_next = 1'b0;
                        state_next      = ST_LIMIT;
                    end
                end
            end
            ST_LIMIT: begin
                // Expiry limit saturates at zero; head read is issued here.
                limit_next = (now_reg > timeout_ext) ? now_reg - timeout_ext : '0;
                ram_raddr  = head_reg;
                state_next = ST_EXPIRE;
            end
            ST_EXPIRE: begin
                if (count_reg != '0 && rd_ts < limit_reg) begin
                    head_next  = slot_after(head_reg, ONE_C);
                    count_next = count_reg - ONE_C;
                    ram_raddr  = slot_after(head_reg, ONE_C);
                end else if (count_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    idx_next   = count_reg;
                    ram_raddr  = slot_after(head_reg, count_reg - ONE_C);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Backward from newest: stop at the first entry not after start.
                if (rd_ts <= start_reg || idx_reg == ONE_C) begin
                    if (rd_ts <= start_reg) begin
                        idx_next = idx_reg;
                    end else begin
                        idx_next = '0;
                    end
                    if (rd_ts <= start_reg && idx_reg == count_reg) begin
                        state_next = ST_FINISH;
                    end else begin
                        ram_raddr  = slot_after(head_reg,
                                                (rd_ts <= start_reg) ? idx_reg : '0);
                        state_next = ST_EMIT;
                    end
                end else begin
                    idx_next  = idx_reg - ONE_C;
                    ram_raddr = slot_after(head_reg, idx_reg - TWO_C);
                end
            end
            ST_EMIT: begin
                // One entry held back so the final match can carry last_item.
                if (rd_ts <= now_reg && hold_valid_reg && !out_free) begin
                    ram_raddr = slot_after(head_reg, idx_reg);
                end else begin
                    if (rd_ts <= now_reg) begin
                        if (hold_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next  = tewq_out_t'{found: 1'b1,
                                                       event_code_out: hold_code_reg,
                                                       event_ts: hold_ts_reg,
                                                       last_item: 1'b0};
                        end
                        hold_valid_next = 1'b1;
                        hold_code_next  = rd_code;
                        hold_ts_next    = rd_ts;
                    end
                    idx_next = idx_reg + ONE_C;
                    if (idx_reg + ONE_C == count_reg) begin
                        state_next = ST_FINISH;
                    end else begin
                        ram_raddr = slot_after(head_reg, idx_reg + ONE_C);
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_data_next     = hold_valid_reg ?
                        tewq_out_t'{found: 1'b1, event_code_out: hold_code_reg,
                                    event_ts: hold_ts_reg, last_item: 1'b1} :
                        tewq_out_t'{found: 1'b0, event_code_out: '0, event_ts: '0,
                                    last_item: 1'b1};
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            timeout_reg    <= timeout_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        now_reg       <= now_next;
        start_reg     <= start_next;
        limit_reg     <= limit_next;
        hold_code_reg <= hold_code_next;
        hold_ts_reg   <= hold_ts_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/tewq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tewq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the timestamped event window queue.
module testbench
    import tewq_pkg::*;
();

    // Ring depth matches the block's default parameter.
    localparam int DEPTH          = RING_DEPTH_DEF;
    // Settle time: the worst query walk over the ring, with margin.
    localparam int SETTLE_CYCLES  = 2 * DEPTH + 16;
    // Long receiver hold-off used once to back the block up.
    localparam int RX_HOLD_CYCLES = 300;
    // Cycles with no handshake on either side before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 40;
    localparam int NUM_PHASES     = 5;
    localparam int MAX_REPORTS    = 10;

    localparam logic [TS_BITS-1:0] MAX_TS = '1;
    // found = 0, code = 0, ts = 0, last = 1: the answer to an empty window.
    localparam tewq_out_t NO_EVENT = {1'b0, {CODE_BITS{1'b0}}, {TS_BITS{1'b0}}, 1'b1};

    typedef struct {
        tewq_in_t  req;
        bit        has_fixed;
        tewq_out_t fixed_res;
    } dir_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    tewq_in_t                s_data;
    logic                    m_valid;
    logic                    m_ready;
    tewq_out_t               m_data;
    logic                    cfg_wr_en;
    logic [TIMEOUT_BITS-1:0] cfg_wr_data;

    // Shadow copy of the ring and its timeout.
    logic [TS_BITS-1:0]      shadow_time [DEPTH];
    logic [CODE_BITS-1:0]    shadow_code [DEPTH];
    int unsigned             shadow_head;
    int unsigned             shadow_fill;
    logic [TIMEOUT_BITS-1:0] shadow_timeout;

    tewq_out_t window_hits[$];     // results of the latest modeled request
    tewq_out_t pending_events[$];  // results still owed by the block
    dir_row_t  dir_rows[$];

    int  bad_count    = 0;
    int  idle_cycles  = 0;
    bit  quiet        = 1'b0;  // no idling on either side while set
    bit  hold_results = 1'b0;  // asks the receiver for one long hold-off

    timestamped_event_window_queue u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Mostly back to back, sometimes a short gap, rarely a long gap.
    function automatic int pick_gap();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Applies one request to the shadow ring; query results land in window_hits.
    function automatic void ring_request(input tewq_in_t req);
        logic [TS_BITS-1:0] timeout_wide;
        logic [TS_BITS-1:0] limit;
        int unsigned        first;
        int unsigned        k;
        int unsigned        slot;
        tewq_out_t          ev;
        window_hits.delete();
        if (req.cmd == CMD_PUSH) begin
            if (shadow_fill >= DEPTH) begin
                // Full: overwrite the oldest slot and move the head past it.
                shadow_time[shadow_head] = req.now_ts;
                shadow_code[shadow_head] = req.event_code;
                shadow_head = (shadow_head + 1) % DEPTH;
            end else begin
                slot = (shadow_head + shadow_fill) % DEPTH;
                shadow_time[slot] = req.now_ts;
                shadow_code[slot] = req.event_code;
                shadow_fill++;
            end
            return;
        end
        // Expiry limit floors at zero instead of wrapping.
        timeout_wide = {{(TS_BITS - TIMEOUT_BITS){1'b0}}, shadow_timeout};
        limit = (req.now_ts > timeout_wide) ? req.now_ts - timeout_wide : '0;
        // Drop from the head only; stops at the first survivor.
        while (shadow_fill > 0 && shadow_time[shadow_head] < limit) begin
            shadow_head = (shadow_head + 1) % DEPTH;
            shadow_fill--;
        end
        // Walk back from the newest entry to the first one at or below start.
        first = 0;
        for (k = shadow_fill; k > 0; k--) begin
            if (shadow_time[(shadow_head + k - 1) % DEPTH] <= req.window_start_ts) begin
                first = k;
                break;
            end
        end
        for (k = first; k < shadow_fill; k++) begin
            slot = (shadow_head + k) % DEPTH;
            if (shadow_time[slot] > req.window_start_ts && shadow_time[slot] <= req.now_ts) begin
                ev.found          = 1'b1;
                ev.event_code_out = shadow_code[slot];
                ev.event_ts       = shadow_time[slot];
                ev.last_item      = 1'b0;
                window_hits       = {window_hits, ev};
            end
        end
        if (window_hits.size() == 0) begin
            window_hits = {window_hits, NO_EVENT};
        end else begin
            window_hits[window_hits.size() - 1].last_item = 1'b1;
        end
    endfunction

    task automatic add_row(input logic cmd, input logic [CODE_BITS-1:0] code,
                           input logic [TS_BITS-1:0] now, input logic [TS_BITS-1:0] start,
                           input bit has_fixed, input tewq_out_t fixed_res);
        dir_row_t row;
        row.req.cmd             = cmd;
        row.req.event_code      = code;
        row.req.now_ts          = now;
        row.req.window_start_ts = start;
        row.has_fixed           = has_fixed;
        row.fixed_res           = fixed_res;
        dir_rows                = {dir_rows, row};
    endtask

    // Drives one request after a random gap and books what it should return.
    task automatic offer(input tewq_in_t req, input bit has_fixed, input tewq_out_t fixed_res);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (s_ready !== 1'b1);
        // Accepted at this edge; the shadow ring advances in request order.
        ring_request(req);
        if (has_fixed) begin
            pending_events = {pending_events, fixed_res};
        end else begin
            pending_events = {pending_events, window_hits};
        end
    endtask

    // Stops offering, waits for every owed result, then lets a trailing push settle.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Timeout writes only happen with the block idle.
    task automatic set_timeout(input logic [TIMEOUT_BITS-1:0] value);
        drain();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        shadow_timeout = value;
    endtask

    task automatic note_mismatch(input string what, input logic [TS_BITS-1:0] want,
                                 input logic [TS_BITS-1:0] got);
        bad_count++;
        if (bad_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
    endtask

    // Receiver: random stalls, plus one long hold-off when asked.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                hold_results = 1'b0;
                stall_left   = RX_HOLD_CYCLES;
            end else if (stall_left == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result checker: every accepted result against the oldest owed one.
    always @(posedge aclk) begin
        tewq_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                note_mismatch("result with no request owing it", '0, m_data.event_ts);
            end else begin
                want = pending_events.pop_front();
                if (m_data.found !== want.found)
                    note_mismatch("found", TS_BITS'(want.found), TS_BITS'(m_data.found));
                if (m_data.event_code_out !== want.event_code_out)
                    note_mismatch("event_code_out", TS_BITS'(want.event_code_out),
                                  TS_BITS'(m_data.event_code_out));
                if (m_data.event_ts !== want.event_ts)
                    note_mismatch("event_ts", want.event_ts, m_data.event_ts);
                if (m_data.last_item !== want.last_item)
                    note_mismatch("last_item", TS_BITS'(want.last_item),
                                  TS_BITS'(m_data.last_item));
            end
        end
    end

    // Watchdog: too long without any handshake means the block is stuck.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        tewq_in_t          req;
        logic [TS_BITS-1:0] clock_us;
        logic [TS_BITS-1:0] span;
        logic [31:0]        timeout_pick;
        int unsigned        step_max;
        int unsigned        push_pct;
        int unsigned        r;

        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        aresetn     = 1'b0;

        shadow_head    = 0;
        shadow_fill    = 0;
        shadow_timeout = TIMEOUT_RESET;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, default timeout of one second.
        // Empty ring right after reset, at both ends of the time range.
        add_row(CMD_QUERY, 16'h0000, 64'd0,  64'd0, 1'b1, NO_EVENT);
        add_row(CMD_QUERY, 16'hFFFF, MAX_TS, 64'd0, 1'b1, NO_EVENT);
        // Three pushes, two with extreme codes; start is don't-care on a push.
        add_row(CMD_PUSH,  16'h0000, 64'd100, MAX_TS, 1'b0, NO_EVENT);
        add_row(CMD_PUSH,  16'hFFFF, 64'd200, 64'd0,  1'b0, NO_EVENT);
        add_row(CMD_PUSH,  16'h1234, 64'd300, MAX_TS, 1'b0, NO_EVENT);
        // Window covering all three.
        add_row(CMD_QUERY, 16'h0000, 64'd300, 64'd99, 1'b0, NO_EVENT);
        // Start equal to now, then start past now: both empty.
        add_row(CMD_QUERY, 16'h0000, 64'd300, 64'd300, 1'b1, NO_EVENT);
        add_row(CMD_QUERY, 16'h0000, 64'd250, 64'd500, 1'b1, NO_EVENT);
        // Newer entry than now is skipped.
        add_row(CMD_QUERY, 16'h0000, 64'd250, 64'd100, 1'b0, NO_EVENT);
        // Stamp from the far future, then an older stamp behind it.
        add_row(CMD_PUSH,  16'hA5A5, MAX_TS,  64'd0,   1'b0, NO_EVENT);
        add_row(CMD_QUERY, 16'h0000, 64'd300, 64'd0,   1'b0, NO_EVENT);
        add_row(CMD_PUSH,  16'h5A5A, 64'd150, 64'd0,   1'b0, NO_EVENT);
        // Backward scan stops at the first entry at or below start.
        add_row(CMD_QUERY, 16'h0000, 64'd400, 64'd120, 1'b0, NO_EVENT);
        // Head expiry stops at a survivor even with an older entry behind it.
        add_row(CMD_QUERY, 16'h0000, 64'd1000250, 64'd0, 1'b0, NO_EVENT);
        // Top of the time range: head expiry stops at the future stamp.
        add_row(CMD_QUERY, 16'hFFFF, MAX_TS, MAX_TS - 64'd1, 1'b0, NO_EVENT);
        add_row(CMD_QUERY, 16'hFFFF, MAX_TS, MAX_TS,         1'b1, NO_EVENT);
        foreach (dir_rows[i]) offer(dir_rows[i].req, dir_rows[i].has_fixed, dir_rows[i].fixed_res);

        // Random part: one timeout setting per phase, extremes included.
        clock_us = 64'd5000;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: timeout_pick = 32'd0;            // head entries older than now expire
                1: timeout_pick = 32'hFFFF_FFFF;    // longest timeout; ring wraps
                2: timeout_pick = TIMEOUT_RESET;
                3: timeout_pick = $urandom_range(2000, 20000);
                default: timeout_pick = $urandom;
            endcase
            set_timeout(timeout_pick);
            push_pct = (ph == 1) ? 85 : 65;
            quiet    = (ph == 2);
            // Back up the result side while requests keep coming.
            if (ph == 1) hold_results = 1'b1;

            // Occasionally jump the time base, including right below wrap-around.
            r = $urandom_range(0, 3);
            if (r == 0)
                clock_us = {$urandom, $urandom};
            else if (r == 1)
                clock_us = MAX_TS - TS_BITS'($urandom_range(0, 50000));
            step_max = $urandom_range(1, 3000);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    // Noise: any field value at all.
                    req.cmd             = 1'($urandom_range(0, 1));
                    req.event_code      = CODE_BITS'($urandom);
                    req.now_ts          = {$urandom, $urandom};
                    req.window_start_ts = {$urandom, $urandom};
                end else if ($urandom_range(0, 99) < push_pct) begin
                    clock_us            = clock_us + TS_BITS'($urandom_range(0, step_max));
                    req.cmd             = CMD_PUSH;
                    req.event_code      = CODE_BITS'($urandom);
                    req.now_ts          = clock_us;
                    req.window_start_ts = {$urandom, $urandom};
                end else begin
                    span                = TS_BITS'($urandom_range(0, 16 * step_max));
                    req.cmd             = CMD_QUERY;
                    req.event_code      = CODE_BITS'($urandom);
                    req.now_ts          = clock_us + TS_BITS'($urandom_range(0, step_max));
                    req.window_start_ts = ($urandom_range(0, 9) == 0) ? 64'd0
                                                                      : req.now_ts - span;
                end
                offer(req, 1'b0, NO_EVENT);
            end
        end

        drain();
        if (bad_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tewq_pkg.sv
src/tewq_ram.sv
src/timestamped_event_window_queue.sv
verif/testbench.sv
